@@ src/brm_pkg.sv @@
// Shared types and constants for the block RMS meter.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package brm_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int LEN_W         = 11;
    localparam int MAX_BLOCK     = 1024;
    localparam int RESET_LEN     = 100;
    localparam int MEAN_SHIFT    = 8;
    localparam int SUM_W         = 35;
    localparam int SQ_W          = 2 * SAMPLE_BITS;
    localparam int NUM_W         = 44;
    localparam int ROOT_W        = NUM_W / 2;
    localparam int REM_W         = ROOT_W + 3;
    localparam int STEP_W        = 6;
    localparam int Q4_W          = 16;
    localparam int MV_W          = 12;
    localparam int MV_NUM_W      = 28;
    localparam int FULL_SCALE_MV = 3300;
    localparam int MV_DENOM      = 65520;
    localparam int MV_HALF       = 32760;
    // 65520 = 4095 << 4
    localparam int MV_DEN_SHIFT  = 4;
    localparam int MV_FOLD_SHIFT = 12;
    localparam int MV_BASE_W     = MV_NUM_W - MV_DEN_SHIFT;
    localparam int MV_FOLD_W     = MV_BASE_W + 1;
    localparam int DIV_STEPS     = NUM_W;
    localparam int SQRT_STEPS    = ROOT_W;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    // register index, taken from paddr[2]
    localparam logic REG_BLOCK_LENGTH = 1'b0;

    typedef logic [LEN_W-1:0] len_t;

    typedef struct packed {
        logic [REM_W-1:0] a;
        logic [REM_W-1:0] b;
    } sub_req_t;

    typedef struct packed {
        logic             ge;
        logic [REM_W-1:0] diff;
    } sub_rsp_t;

    typedef struct packed {
        logic busy;
        logic result_pending;
    } seq_status_t;

endpackage

`default_nettype wire

@@ src/brm_in_if.sv @@
// Input channel: one converter sample per word.
// Depends on brm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface brm_in_if;
    import brm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

@@ src/brm_out_if.sv @@
// Output channel: one RMS result per word.
// Depends on brm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface brm_out_if;
    import brm_pkg::*;

    logic            valid;
    logic            ready;
    logic [Q4_W-1:0] rms_q4;
    logic [MV_W-1:0] rms_millivolts;

    modport source (output valid, output rms_q4, output rms_millivolts, input ready);
    modport sink   (input valid, input rms_q4, input rms_millivolts, output ready);
endinterface

`default_nettype wire

@@ src/brm_cfg.sv @@
// APB register file: block_length, clamped to the usable range.
// Depends on brm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brm_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [brm_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [brm_pkg::PDATA_W-1:0]  pwdata,
    output logic      [brm_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    output brm_pkg::len_t                     len
);
    import brm_pkg::*;

    len_t len_reg;
    logic wr_en;
    logic sel_len;

    assign pready  = 1'b1;
    assign sel_len = (paddr[PADDR_W-1] == REG_BLOCK_LENGTH);
    assign wr_en   = psel && penable && pwrite && pready && sel_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_W'(RESET_LEN);
        end
        else if (wr_en)
        begin
            len_reg <= pwdata[LEN_W-1:0];
        end
    end

    assign prdata = sel_len ? PDATA_W'(len_reg) : '0;

    always_comb
    begin
        if (len_reg == '0)
        begin
            len = LEN_W'(1);
        end
        else if (len_reg > LEN_W'(MAX_BLOCK))
        begin
            len = LEN_W'(MAX_BLOCK);
        end
        else
        begin
            len = len_reg;
        end
    end
endmodule

`default_nettype wire

@@ src/brm_sub.sv @@
// Shared compare-and-subtract unit used by the divide and root steps.
// Depends on brm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brm_sub (
    input  wire brm_pkg::sub_req_t req,
    output brm_pkg::sub_rsp_t      rsp
);
    import brm_pkg::*;

    logic [REM_W:0] wide;

    assign wide     = {1'b0, req.a} - {1'b0, req.b};
    assign rsp.ge   = ~wide[REM_W];
    assign rsp.diff = wide[REM_W-1:0];
endmodule

`default_nettype wire

@@ src/brm_seq.sv @@
// Sequencer and datapath: accumulation, restoring divide and digit-by-digit
// square root stepping through brm_sub, then millivolt scaling.
// Depends on brm_pkg, brm_in_if, brm_out_if.
`timescale 1ns / 1ps
`default_nettype none

module brm_seq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    brm_in_if.sink                 din,
    brm_out_if.source              dout,
    input  wire brm_pkg::len_t     len,
    output brm_pkg::sub_req_t      sub_req,
    input  wire brm_pkg::sub_rsp_t sub_rsp,
    output brm_pkg::seq_status_t   status
);
    import brm_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ACC  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_SQRT = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_MV   = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    logic [2:0]             state_reg, state_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    len_t                   count_reg, count_next;
    logic [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [NUM_W-1:0]       num_reg, num_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [ROOT_W-1:0]      root_reg, root_next;
    logic [Q4_W-1:0]        q4_reg, q4_next;
    logic                   out_valid_reg, out_valid_next;
    logic [Q4_W-1:0]        out_q4_reg, out_q4_next;
    logic [MV_W-1:0]        out_mv_reg, out_mv_next;

    logic [SQ_W-1:0]        sq;
    logic [SUM_W-1:0]       sum_new;
    len_t                   count_new;
    logic [Q4_W-1:0]        q4_sat;
    logic [MV_NUM_W-1:0]    mv_num;
    logic [MV_BASE_W-1:0]   mv_base;
    logic [MV_FOLD_W-1:0]   mv_fold;
    logic [MV_W-1:0]        mv_quot;
    logic [MV_W-1:0]        mv_sat;
    logic                   out_free;

    assign sq        = SQ_W'(sample_reg) * SQ_W'(sample_reg);
    assign sum_new   = sum_reg + SUM_W'(sq);
    assign count_new = count_reg + LEN_W'(1);
    assign q4_sat    = (|root_reg[ROOT_W-1:Q4_W]) ? '1 : root_reg[Q4_W-1:0];
    assign mv_num    = MV_NUM_W'(q4_sat) * MV_NUM_W'(FULL_SCALE_MV) + MV_NUM_W'(MV_HALF);
    // x / 65520 = (x >> 4) / 4095; y / 4095 = (y + (y >> 12) + 1) >> 12 for quotients below 4096
    assign mv_base   = num_reg[MV_NUM_W-1:MV_DEN_SHIFT];
    assign mv_fold   = MV_FOLD_W'(mv_base) + MV_FOLD_W'(mv_base >> MV_FOLD_SHIFT) +
                       MV_FOLD_W'(1);
    assign mv_quot   = mv_fold[MV_FOLD_SHIFT +: MV_W];
    assign mv_sat    = (num_reg[MV_W-1:0] > MV_W'(FULL_SCALE_MV)) ?
                       MV_W'(FULL_SCALE_MV) : num_reg[MV_W-1:0];
    assign out_free  = !out_valid_reg || dout.ready;

    always_comb
    begin
        case (state_reg)
            ST_DIV:
            begin
                sub_req.a = REM_W'({rem_reg[LEN_W-1:0], num_reg[NUM_W-1]});
                sub_req.b = REM_W'(len);
            end
            ST_SQRT:
            begin
                sub_req.a = {rem_reg[REM_W-3:0], num_reg[NUM_W-1 -: 2]};
                sub_req.b = REM_W'({root_reg, 2'b01});
            end
            default:
            begin
                sub_req.a = '0;
                sub_req.b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        sample_next    = sample_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        q4_next        = q4_reg;
        out_valid_next = out_valid_reg;
        out_q4_next    = out_q4_reg;
        out_mv_next    = out_mv_reg;

        if (out_valid_reg && dout.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (din.valid)
                begin
                    sample_next = din.sample;
                    state_next  = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (count_new >= len)
                begin
                    num_next   = {1'b0, sum_new, MEAN_SHIFT'(0)};
                    rem_next   = '0;
                    sum_next   = '0;
                    count_next = '0;
                    step_next  = STEP_W'(DIV_STEPS - 1);
                    state_next = ST_DIV;
                end
                else
                begin
                    sum_next   = sum_new;
                    count_next = count_new;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                rem_next  = sub_rsp.ge ? sub_rsp.diff : sub_req.a;
                num_next  = {num_reg[NUM_W-2:0], sub_rsp.ge};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = STEP_W'(SQRT_STEPS - 1);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                rem_next  = sub_rsp.ge ? sub_rsp.diff : sub_req.a;
                root_next = {root_reg[ROOT_W-2:0], sub_rsp.ge};
                num_next  = {num_reg[NUM_W-3:0], 2'b00};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                q4_next    = q4_sat;
                num_next   = NUM_W'(mv_num);
                state_next = ST_MV;
            end
            ST_MV:
            begin
                num_next   = NUM_W'(mv_quot);
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_q4_next    = q4_reg;
                    out_mv_next    = mv_sat;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        q4_reg     <= q4_next;
        out_q4_reg <= out_q4_next;
        out_mv_reg <= out_mv_next;
    end

    assign din.ready           = (state_reg == ST_IDLE);
    assign dout.valid          = out_valid_reg;
    assign dout.rms_q4         = out_q4_reg;
    assign dout.rms_millivolts = out_mv_reg;

    assign status.busy           = (state_reg != ST_IDLE);
    assign status.result_pending = (state_reg == ST_FIN);
endmodule

`default_nettype wire

@@ src/block_rms_meter_unit.sv @@
// Block RMS meter top level: APB register, sequencer and shared subtractor.
// Depends on brm_pkg, brm_in_if, brm_out_if, brm_cfg, brm_sub, brm_seq.
// A sample word is accepted, then squared and accumulated; the sample that completes
// a block goes through these steps before its result word is offered:
// accept, accumulate, 44 restoring-divide steps and 22 square-root steps through
// one shared compare-subtract unit, then multiply, millivolt scale and output load.
// The result sits in an output register, so the next sample is taken while it
// waits; a second result holds the sequencer, and with it the input, until the
// first drains.
`timescale 1ns / 1ps
`default_nettype none

module block_rms_meter_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    brm_in_if.sink                            din,
    brm_out_if.source                         dout,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [brm_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [brm_pkg::PDATA_W-1:0]  pwdata,
    output logic      [brm_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready
);
    import brm_pkg::*;

    len_t        len;
    sub_req_t    sub_req;
    sub_rsp_t    sub_rsp;
    seq_status_t status;

    brm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .len     (len)
    );

    brm_sub u_sub (
        .req (sub_req),
        .rsp (sub_rsp)
    );

    brm_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .din     (din),
        .dout    (dout),
        .len     (len),
        .sub_req (sub_req),
        .sub_rsp (sub_rsp),
        .status  (status)
    );

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        status.busy |-> !din.ready)
        else $error("input ready while sequencer busy");

    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (din.valid && din.ready) |=> status.busy)
        else $error("accepted word did not start work");

    a_pending_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (status.result_pending && dout.valid && !dout.ready) |=> status.result_pending)
        else $error("result dropped while output stalled");

    a_mv_range: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid |-> (dout.rms_millivolts <= MV_W'(FULL_SCALE_MV)))
        else $error("millivolt result out of range");
endmodule

`default_nettype wire
